[rtl/mcpid_pkg.sv]
// Package for the multi-channel PID regulator: field widths, operation codes,
// per-channel default gain and limit tables, stage payload types.
// No dependencies.
package mcpid_pkg;

  localparam int unsigned DEFAULT_CHANNELS       = 20;
  localparam int unsigned DEFAULT_GAIN_FRAC_BITS = 8;
  localparam int unsigned DEFAULT_ROWS           = 20;

  localparam int unsigned CH_W          = 5;
  localparam int unsigned SMP_W         = 16;
  localparam int unsigned ERR_W         = 17;
  localparam int unsigned INT_W         = 18;
  localparam int unsigned DIFF_W        = 18;
  localparam int unsigned DRIVE_W       = 16;
  localparam int unsigned LIM_W         = 16;
  localparam int unsigned BAND_W        = 8;
  localparam int unsigned GAIN_INT_BITS = 8;
  localparam int unsigned TENTHS_W      = 16;

  localparam logic OP_PID = 1'b0;
  localparam logic OP_PI  = 1'b1;

  localparam logic [TENTHS_W-1:0] KP_TENTHS [DEFAULT_ROWS] = '{
    16'd60, 16'd0, 16'd60, 16'd0, 16'd60, 16'd0, 16'd60, 16'd0, 16'd1300, 16'd0,
    16'd0, 16'd400, 16'd130, 16'd1500, 16'd100, 16'd950, 16'd0, 16'd40, 16'd60, 16'd0};
  localparam logic [TENTHS_W-1:0] KI_TENTHS [DEFAULT_ROWS] = '{
    16'd8, 16'd0, 16'd8, 16'd0, 16'd8, 16'd0, 16'd8, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd11, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam logic [TENTHS_W-1:0] KD_TENTHS [DEFAULT_ROWS] = '{
    16'd80, 16'd0, 16'd80, 16'd0, 16'd80, 16'd0, 16'd80, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam logic [LIM_W-1:0] INT_LIM_DEFAULT [DEFAULT_ROWS] = '{
    16'd5000, 16'd0, 16'd5000, 16'd0, 16'd5000, 16'd0, 16'd5000, 16'd0, 16'd1000, 16'd0,
    16'd0, 16'd33000, 16'd33000, 16'd1000, 16'd30000, 16'd1000, 16'd0, 16'd30000,
    16'd30000, 16'd0};
  localparam logic [LIM_W-1:0] OUT_LIM_DEFAULT [DEFAULT_ROWS] = '{
    16'd9000, 16'd0, 16'd9000, 16'd0, 16'd9000, 16'd0, 16'd9000, 16'd0, 16'd15000, 16'd0,
    16'd0, 16'd20000, 16'd20000, 16'd15000, 16'd2000, 16'd20000, 16'd0, 16'd3000,
    16'd3000, 16'd0};
  localparam logic [BAND_W-1:0] BAND_DEFAULT [DEFAULT_ROWS] = '{
    8'd5, 8'd0, 8'd5, 8'd0, 8'd5, 8'd0, 8'd5, 8'd0, 8'd2, 8'd0,
    8'd0, 8'd5, 8'd2, 8'd1, 8'd2, 8'd1, 8'd0, 8'd2, 8'd2, 8'd0};

  // Round a gain given in tenths to fixed point with frac fraction bits.
  function automatic logic [31:0] tenths_to_gain(input logic [TENTHS_W-1:0] tenths,
                                                 input int unsigned frac);
    logic [63:0] scaled;
    scaled = 64'(tenths) << frac;
    return 32'((scaled + 64'd5) / 64'd10);
  endfunction

  typedef struct packed {
    logic                    operation;
    logic [CH_W-1:0]         channel;
    logic signed [SMP_W-1:0] setpoint;
    logic signed [SMP_W-1:0] measurement;
    logic signed [ERR_W-1:0] error_in;
  } req_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W-1:0]  integ;
    logic signed [DIFF_W-1:0] diff;
    logic [CH_W-1:0]          channel;
    logic                     in_range;
  } s1_t;

endpackage

[rtl/mcpid_if.sv]
// Valid/ready channel interfaces for the PID regulator sample and drive streams.
// Depends on mcpid_pkg.
interface mcpid_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     operation;
  logic [mcpid_pkg::CH_W-1:0]               channel;
  logic signed [mcpid_pkg::SMP_W-1:0]       setpoint;
  logic signed [mcpid_pkg::SMP_W-1:0]       measurement;
  logic signed [mcpid_pkg::ERR_W-1:0]       error_in;

  modport source (output valid, operation, channel, setpoint, measurement, error_in,
                  input ready);
  modport sink   (input valid, operation, channel, setpoint, measurement, error_in,
                  output ready);
endinterface

interface mcpid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcpid_pkg::DRIVE_W-1:0] drive;
  logic [mcpid_pkg::CH_W-1:0]           channel_out;

  modport source (output valid, drive, channel_out, input ready);
  modport sink   (input valid, drive, channel_out, output ready);
endinterface

[rtl/mcpid_state_stage.sv]
// Error, deadband and integral stage with the per-channel loop state.
// Depends on mcpid_pkg.
module mcpid_state_stage #(
  parameter int unsigned CHANNELS = mcpid_pkg::DEFAULT_CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              load_i,
  input  mcpid_pkg::req_t   req_i,
  output mcpid_pkg::s1_t    s1_o
);
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUM_W = mcpid_pkg::INT_W + 1;

  logic signed [mcpid_pkg::INT_W-1:0]  integ_q [CHANNELS];
  logic signed [mcpid_pkg::ERR_W-1:0]  prev_q  [CHANNELS];
  logic [mcpid_pkg::BAND_W-1:0]        band_tab [CHANNELS];
  logic [mcpid_pkg::LIM_W-1:0]         ilim_tab [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_tab
    if (c < mcpid_pkg::DEFAULT_ROWS) begin : g_def
      assign band_tab[c] = mcpid_pkg::BAND_DEFAULT[c];
      assign ilim_tab[c] = mcpid_pkg::INT_LIM_DEFAULT[c];
    end else begin : g_zero
      assign band_tab[c] = '0;
      assign ilim_tab[c] = '0;
    end
  end

  logic [IDX_W-1:0]                     idx;
  logic                                 in_range;
  logic [mcpid_pkg::BAND_W-1:0]         band;
  logic [mcpid_pkg::LIM_W-1:0]          ilim;
  logic signed [mcpid_pkg::INT_W-1:0]   integ_rd;
  logic signed [mcpid_pkg::ERR_W-1:0]   prev_rd;
  logic signed [mcpid_pkg::ERR_W-1:0]   err_raw;
  logic [mcpid_pkg::ERR_W-1:0]          mag;
  logic signed [mcpid_pkg::ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]              isum;
  logic signed [SUM_W-1:0]              ilim_s;
  logic signed [SUM_W-1:0]              iclamp;
  logic signed [mcpid_pkg::DIFF_W-1:0]  diff;
  mcpid_pkg::s1_t                       s1_d, s1_q;

  assign idx      = IDX_W'(req_i.channel);
  assign in_range = 32'(req_i.channel) < CHANNELS;
  assign band     = in_range ? band_tab[idx] : '0;
  assign ilim     = in_range ? ilim_tab[idx] : '0;
  assign integ_rd = in_range ? integ_q[idx] : '0;
  assign prev_rd  = in_range ? prev_q[idx]  : '0;

  always_comb begin
    if (req_i.operation == mcpid_pkg::OP_PID) begin
      err_raw = mcpid_pkg::ERR_W'(req_i.setpoint) - mcpid_pkg::ERR_W'(req_i.measurement);
    end else begin
      err_raw = req_i.error_in;
    end
    mag = err_raw[mcpid_pkg::ERR_W-1] ? mcpid_pkg::ERR_W'(-err_raw) : err_raw;
    err = (mag <= mcpid_pkg::ERR_W'(band)) ? '0 : err_raw;

    isum   = SUM_W'(integ_rd) + SUM_W'(err);
    ilim_s = $signed(SUM_W'(ilim));
    if (isum > ilim_s) begin
      iclamp = ilim_s;
    end else if (isum < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = isum;
    end

    // PI requests carry no derivative term
    if (req_i.operation == mcpid_pkg::OP_PID) begin
      diff = mcpid_pkg::DIFF_W'(err) - mcpid_pkg::DIFF_W'(prev_rd);
    end else begin
      diff = '0;
    end

    s1_d.err      = err;
    s1_d.integ    = mcpid_pkg::INT_W'(iclamp);
    s1_d.diff     = diff;
    s1_d.channel  = req_i.channel;
    s1_d.in_range = in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        integ_q[c] <= '0;
        prev_q[c]  <= '0;
      end
    end else if (fire_i && in_range) begin
      integ_q[idx] <= s1_d.integ;
      if (req_i.operation == mcpid_pkg::OP_PID) begin
        prev_q[idx] <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

[rtl/mcpid_mult_stage.sv]
// Gain multiply stage: three parallel signed products against the channel's gains.
// Depends on mcpid_pkg.
module mcpid_mult_stage #(
  parameter int unsigned CHANNELS       = mcpid_pkg::DEFAULT_CHANNELS,
  parameter int unsigned GAIN_FRAC_BITS = mcpid_pkg::DEFAULT_GAIN_FRAC_BITS,
  localparam int unsigned GW = mcpid_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS,
  localparam int unsigned PW = GW + 1 + mcpid_pkg::DIFF_W
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  mcpid_pkg::s1_t               s1_i,
  output logic signed [PW-1:0]         p_kp_o,
  output logic signed [PW-1:0]         p_ki_o,
  output logic signed [PW-1:0]         p_kd_o,
  output logic [mcpid_pkg::CH_W-1:0]   channel_o,
  output logic                         in_range_o
);
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [GW-1:0] kp_tab [CHANNELS];
  logic [GW-1:0] ki_tab [CHANNELS];
  logic [GW-1:0] kd_tab [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_tab
    if (c < mcpid_pkg::DEFAULT_ROWS) begin : g_def
      assign kp_tab[c] = GW'(mcpid_pkg::tenths_to_gain(mcpid_pkg::KP_TENTHS[c], GAIN_FRAC_BITS));
      assign ki_tab[c] = GW'(mcpid_pkg::tenths_to_gain(mcpid_pkg::KI_TENTHS[c], GAIN_FRAC_BITS));
      assign kd_tab[c] = GW'(mcpid_pkg::tenths_to_gain(mcpid_pkg::KD_TENTHS[c], GAIN_FRAC_BITS));
    end else begin : g_zero
      assign kp_tab[c] = '0;
      assign ki_tab[c] = '0;
      assign kd_tab[c] = '0;
    end
  end

  logic [IDX_W-1:0]     idx;
  logic signed [GW:0]   kp_s, ki_s, kd_s;
  logic signed [PW-1:0] p_kp_d, p_ki_d, p_kd_d;
  logic signed [PW-1:0] p_kp_q, p_ki_q, p_kd_q;
  logic [mcpid_pkg::CH_W-1:0] channel_q;
  logic                 in_range_q;

  assign idx  = IDX_W'(s1_i.channel);
  assign kp_s = s1_i.in_range ? $signed({1'b0, kp_tab[idx]}) : '0;
  assign ki_s = s1_i.in_range ? $signed({1'b0, ki_tab[idx]}) : '0;
  assign kd_s = s1_i.in_range ? $signed({1'b0, kd_tab[idx]}) : '0;

  assign p_kp_d = PW'(kp_s) * PW'(s1_i.err);
  assign p_ki_d = PW'(ki_s) * PW'(s1_i.integ);
  assign p_kd_d = PW'(kd_s) * PW'(s1_i.diff);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_kp_q     <= p_kp_d;
      p_ki_q     <= p_ki_d;
      p_kd_q     <= p_kd_d;
      channel_q  <= s1_i.channel;
      in_range_q <= s1_i.in_range;
    end
  end

  assign p_kp_o     = p_kp_q;
  assign p_ki_o     = p_ki_q;
  assign p_kd_o     = p_kd_q;
  assign channel_o  = channel_q;
  assign in_range_o = in_range_q;

endmodule

[rtl/mcpid_out_stage.sv]
// Output stage: sum the products, floor-shift out the gain fraction, clamp to the
// channel's output limit and to the drive range. Depends on mcpid_pkg.
module mcpid_out_stage #(
  parameter int unsigned CHANNELS       = mcpid_pkg::DEFAULT_CHANNELS,
  parameter int unsigned GAIN_FRAC_BITS = mcpid_pkg::DEFAULT_GAIN_FRAC_BITS,
  localparam int unsigned PW = mcpid_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS + 1 + mcpid_pkg::DIFF_W
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic signed [PW-1:0]                p_kp_i,
  input  logic signed [PW-1:0]                p_ki_i,
  input  logic signed [PW-1:0]                p_kd_i,
  input  logic [mcpid_pkg::CH_W-1:0]          channel_i,
  input  logic                                in_range_i,
  output logic signed [mcpid_pkg::DRIVE_W-1:0] drive_o,
  output logic [mcpid_pkg::CH_W-1:0]          channel_o
);
  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW    = PW + 2;
  localparam logic signed [SW-1:0] DRIVE_MAX = SW'(32767);
  localparam logic signed [SW-1:0] DRIVE_MIN = SW'(-32768);

  logic [mcpid_pkg::LIM_W-1:0] olim_tab [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_tab
    if (c < mcpid_pkg::DEFAULT_ROWS) begin : g_def
      assign olim_tab[c] = mcpid_pkg::OUT_LIM_DEFAULT[c];
    end else begin : g_zero
      assign olim_tab[c] = '0;
    end
  end

  logic [IDX_W-1:0]             idx;
  logic signed [SW-1:0]         sum;
  logic signed [SW-1:0]         shifted;
  logic signed [SW-1:0]         olim;
  logic signed [SW-1:0]         clamped;
  logic signed [SW-1:0]         sat;
  logic signed [mcpid_pkg::DRIVE_W-1:0] drive_d, drive_q;
  logic [mcpid_pkg::CH_W-1:0]   channel_q;

  assign idx = IDX_W'(channel_i);

  always_comb begin
    sum     = SW'(p_kp_i) + SW'(p_ki_i) + SW'(p_kd_i);
    shifted = sum >>> GAIN_FRAC_BITS;
    olim    = in_range_i ? $signed(SW'(olim_tab[idx])) : '0;
    if (shifted > olim) begin
      clamped = olim;
    end else if (shifted < -olim) begin
      clamped = -olim;
    end else begin
      clamped = shifted;
    end
    if (clamped > DRIVE_MAX) begin
      sat = DRIVE_MAX;
    end else if (clamped < DRIVE_MIN) begin
      sat = DRIVE_MIN;
    end else begin
      sat = clamped;
    end
    drive_d = in_range_i ? mcpid_pkg::DRIVE_W'(sat) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q   <= drive_d;
      channel_q <= channel_i;
    end
  end

  assign drive_o   = drive_q;
  assign channel_o = channel_q;

endmodule

[rtl/multi_channel_pid_regulator.sv]
// Multi-channel positional PID regulator, top level: pipeline control and stages.
// Depends on mcpid_pkg, mcpid_if, mcpid_state_stage, mcpid_mult_stage, mcpid_out_stage.
//
//   port   | dir | carries                                           | handshake
//   -------+-----+---------------------------------------------------+----------
//   in_i   | in  | operation, channel, setpoint, measurement, error_in | valid/ready
//   out_o  | out | drive, channel_out (one per accepted sample)        | valid/ready
//
// One sample per cycle sustained while the output is not stalled; each accepted sample
// passes through the input register, state stage, multiply stage and output register.
// The per-channel integral and previous error are read and written in the single
// state stage, so samples on the same channel may follow each other every cycle.
// rst_ni clears all pipeline valid bits and the loop state at once; gains and limits
// are constant tables, so there is no clearing pass.
// A stalled output holds its result; the stages behind it keep advancing into
// bubbles, so the input keeps taking samples until every stage is full.
module multi_channel_pid_regulator #(
  parameter int unsigned CHANNELS       = mcpid_pkg::DEFAULT_CHANNELS,
  parameter int unsigned GAIN_FRAC_BITS = mcpid_pkg::DEFAULT_GAIN_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcpid_in_if.sink    in_i,
  mcpid_out_if.source out_o
);
  localparam int unsigned PW =
    mcpid_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS + 1 + mcpid_pkg::DIFF_W;

  // Valid bit per stage: input register, state stage, multiply stage, output.
  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;
  logic in_take;
  mcpid_pkg::req_t req_q;
  mcpid_pkg::s1_t  s1;

  logic signed [PW-1:0]       p_kp, p_ki, p_kd;
  logic [mcpid_pkg::CH_W-1:0] mult_channel;
  logic                       mult_in_range;

  // A stage may load when it is empty or its contents move on this cycle.
  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  assign in_i.ready = adv0;
  assign in_take    = in_i.valid && adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_i.valid;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Capture the sample transaction.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.operation   <= in_i.operation;
      req_q.channel     <= in_i.channel;
      req_q.setpoint    <= in_i.setpoint;
      req_q.measurement <= in_i.measurement;
      req_q.error_in    <= in_i.error_in;
    end
  end

  // Loop state is updated exactly once, as the sample leaves the input register.
  mcpid_state_stage #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (v0_q && adv1),
    .load_i (adv1),
    .req_i  (req_q),
    .s1_o   (s1)
  );

  mcpid_mult_stage #(
    .CHANNELS       (CHANNELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mult (
    .clk_i      (clk_i),
    .load_i     (adv2),
    .s1_i       (s1),
    .p_kp_o     (p_kp),
    .p_ki_o     (p_ki),
    .p_kd_o     (p_kd),
    .channel_o  (mult_channel),
    .in_range_o (mult_in_range)
  );

  mcpid_out_stage #(
    .CHANNELS       (CHANNELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .load_i     (adv3),
    .p_kp_i     (p_kp),
    .p_ki_i     (p_ki),
    .p_kd_i     (p_kd),
    .channel_i  (mult_channel),
    .in_range_i (mult_in_range),
    .drive_o    (out_o.drive),
    .channel_o  (out_o.channel_out)
  );

  assign out_o.valid = v3_q;

endmodule

[rtl/mcpid_checker.sv]
// Port-level checks for the PID regulator, bound to the top level.
// Depends on mcpid_pkg and multi_channel_pid_regulator.
module mcpid_checker #(
  parameter int unsigned CHANNELS = mcpid_pkg::DEFAULT_CHANNELS
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [mcpid_pkg::DRIVE_W-1:0] drive_i,
  input logic [mcpid_pkg::CH_W-1:0]           channel_out_i
);
  logic in_acc;
  int   out_lim;

  assign in_acc = in_valid_i && in_ready_i;

  always_comb begin
    if ((32'(channel_out_i) < CHANNELS) &&
        (32'(channel_out_i) < mcpid_pkg::DEFAULT_ROWS)) begin
      out_lim = int'(mcpid_pkg::OUT_LIM_DEFAULT[channel_out_i]);
    end else begin
      out_lim = 0;
    end
  end

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i) && $stable(channel_out_i))
    else $error("stalled result changed");

  // Drive stays within the channel's output limit; unknown channels give zero.
  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(drive_i) <= out_lim) && (int'(drive_i) >= -out_lim))
    else $error("drive outside channel output limit");

  // Input backpressure only comes from a full pipeline behind a stalled output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output stall");

  // With no new samples and a free output long enough to empty every stage, the pipeline is drained.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) && !$past(in_acc, 4) &&
    $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3) &&
    $past(out_ready_i, 4) && $past(rst_ni, 4) |-> !out_valid_i)
    else $error("result appeared without a sample");

endmodule

bind multi_channel_pid_regulator mcpid_checker #(
  .CHANNELS (CHANNELS)
) u_mcpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .drive_i       (out_o.drive),
  .channel_out_i (out_o.channel_out)
);

[sim/tb_multi_channel_pid_regulator.sv]
// Self-checking testbench for multi_channel_pid_regulator: a directed and random
// sample stream with an in-order predictor of the 20 PID loops checked on the drive side.
// Depends on mcpid_pkg, mcpid_if and the regulator RTL.
module tb_multi_channel_pid_regulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_LOOPS    = mcpid_pkg::DEFAULT_CHANNELS;
  localparam int unsigned FRAC       = mcpid_pkg::DEFAULT_GAIN_FRAC_BITS;
  localparam int unsigned HOLD_OFF   = 200;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned DRAIN_MAX  = 100000;

  // One expected transaction on the drive stream.
  typedef struct {
    logic signed [mcpid_pkg::DRIVE_W-1:0] drive;
    logic [mcpid_pkg::CH_W-1:0]           channel;
  } drive_exp_t;

  logic clk_i;
  logic rst_ni;

  mcpid_in_if  in_if ();
  mcpid_out_if out_if ();

  multi_channel_pid_regulator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Loop state as the predictor sees it: integral and last error per channel.
  longint loop_integral [N_LOOPS];
  longint loop_prev_err [N_LOOPS];

  drive_exp_t pending_drives[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned samples_sent;
  int unsigned directed_sent;
  int unsigned drives_checked;
  int unsigned backpressure_cycles;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  initial begin
    #1000000;
    $display("Timeout: %0d drive transactions still pending", pending_drives.size());
    $display("tb_multi_channel_pid_regulator NOT OK");
    $finish;
  end

  // Q8.8 gain from a value given in tenths, rounded to nearest.
  function automatic longint q_gain(input logic [mcpid_pkg::TENTHS_W-1:0] tenths);
    return ((longint'(tenths) << FRAC) + 5) / 10;
  endfunction

  function automatic longint clamp_mag(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advance one loop by one sample and return the drive it produces.
  function automatic drive_exp_t predict_drive(input mcpid_pkg::req_t s);
    drive_exp_t r;
    longint err, integ, acc, drv;
    int unsigned ch;
    r.channel = s.channel;
    r.drive   = '0;
    ch = s.channel;
    if (ch >= N_LOOPS) return r;

    if (s.operation == mcpid_pkg::OP_PID)
      err = longint'($signed(s.setpoint)) - longint'($signed(s.measurement));
    else
      err = longint'($signed(s.error_in));

    // Deadband: small errors count as none at all.
    if ((err < 0 ? -err : err) <= longint'(mcpid_pkg::BAND_DEFAULT[ch])) err = 0;

    integ = clamp_mag(loop_integral[ch] + err, longint'(mcpid_pkg::INT_LIM_DEFAULT[ch]));
    loop_integral[ch] = integ;

    acc = q_gain(mcpid_pkg::KP_TENTHS[ch]) * err + q_gain(mcpid_pkg::KI_TENTHS[ch]) * integ;
    if (s.operation == mcpid_pkg::OP_PID) begin
      acc += q_gain(mcpid_pkg::KD_TENTHS[ch]) * (err - loop_prev_err[ch]);
      loop_prev_err[ch] = err;
    end

    drv = clamp_mag(acc >>> FRAC, longint'(mcpid_pkg::OUT_LIM_DEFAULT[ch]));
    if (drv > 32767) drv = 32767;
    if (drv < -32768) drv = -32768;
    r.drive = mcpid_pkg::DRIVE_W'(drv);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORT)
      $display("Mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Predict on every accepted sample, check every accepted drive against the oldest
  // prediction. The input side goes first so a pass-through path would still line up.
  always @(posedge clk_i) begin : drive_check
    mcpid_pkg::req_t seen;
    drive_exp_t      want;
    if (rst_ni) begin
      if (in_if.valid && !in_if.ready) backpressure_cycles++;
      if (in_if.valid && in_if.ready) begin
        seen.operation   = in_if.operation;
        seen.channel     = in_if.channel;
        seen.setpoint    = in_if.setpoint;
        seen.measurement = in_if.measurement;
        seen.error_in    = in_if.error_in;
        pending_drives.push_back(predict_drive(seen));
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("unrequested drive on channel", -1, out_if.channel_out);
        end else begin
          want = pending_drives.pop_front();
          drives_checked++;
          if (out_if.channel_out !== want.channel)
            report_mismatch("channel_out", want.channel, out_if.channel_out);
          if (out_if.drive !== want.drive)
            report_mismatch($sformatf("drive of channel %0d", want.channel),
                            want.drive, $signed(out_if.drive));
        end
      end
    end
  end

  // Drive side: random stalls, or a long hold-off when a test asks for one.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic mcpid_pkg::req_t make_sample(input logic op, input int ch, input int sp,
                                                  input int meas, input int err);
    mcpid_pkg::req_t s;
    s.operation   = op;
    s.channel     = mcpid_pkg::CH_W'(ch);
    s.setpoint    = mcpid_pkg::SMP_W'(sp);
    s.measurement = mcpid_pkg::SMP_W'(meas);
    s.error_in    = mcpid_pkg::ERR_W'(err);
    return s;
  endfunction

  // Offer one sample and hold it until the block takes it. Valid stays high across
  // back-to-back transactions; it drops only for idle cycles in front of a sample.
  task automatic send_sample(input mcpid_pkg::req_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= s.operation;
    in_if.channel     <= s.channel;
    in_if.setpoint    <= s.setpoint;
    in_if.measurement <= s.measurement;
    in_if.error_in    <= s.error_in;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    samples_sent++;
  endtask

  // Mostly realistic loop traffic, with deadband-edge errors, extremes and a few
  // samples for channels that do not exist.
  function automatic mcpid_pkg::req_t random_sample();
    mcpid_pkg::req_t s;
    int sp, dev;
    s.operation   = 1'($urandom_range(1));
    s.channel     = ($urandom_range(15) == 0)
                    ? mcpid_pkg::CH_W'($urandom_range(31, N_LOOPS))
                    : mcpid_pkg::CH_W'($urandom_range(N_LOOPS - 1));
    s.setpoint    = mcpid_pkg::SMP_W'($urandom);
    s.measurement = mcpid_pkg::SMP_W'($urandom);
    s.error_in    = mcpid_pkg::ERR_W'($urandom);
    sp = int'($urandom_range(32000)) - 16000;
    case ($urandom_range(3))
      0: ; // full-range noise
      1: begin
        dev = int'($urandom_range(16)) - 8;
        s.setpoint    = mcpid_pkg::SMP_W'(sp);
        s.measurement = mcpid_pkg::SMP_W'(sp - dev);
        s.error_in    = mcpid_pkg::ERR_W'(dev);
      end
      2: begin
        dev = int'($urandom_range(4000)) - 2000;
        s.setpoint    = mcpid_pkg::SMP_W'(sp);
        s.measurement = mcpid_pkg::SMP_W'(sp - dev);
        s.error_in    = mcpid_pkg::ERR_W'(dev);
      end
      default: begin
        s.setpoint    = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        s.measurement = ~s.setpoint;
        s.error_in    = $urandom_range(1) ? 17'sh0ffff : 17'sh10000;
      end
    endcase
    return s;
  endfunction

  // Deadband on channel 0 (band 5): both edges, both signs, both operations.
  task automatic test_deadband();
    send_sample(make_sample(mcpid_pkg::OP_PID, 0, 5, 0, 0));
    send_sample(make_sample(mcpid_pkg::OP_PID, 0, 0, 6, 0));
    send_sample(make_sample(mcpid_pkg::OP_PI, 0, 0, 0, -5));
    send_sample(make_sample(mcpid_pkg::OP_PI, 0, 0, 0, 6));
  endtask

  // Widest errors from both operations, on the high-gain channels.
  task automatic test_error_extremes();
    send_sample(make_sample(mcpid_pkg::OP_PID, 11, 32767, -32768, 0));
    send_sample(make_sample(mcpid_pkg::OP_PID, 11, -32768, 32767, 0));
    send_sample(make_sample(mcpid_pkg::OP_PI, 13, 0, 0, -65536));
    send_sample(make_sample(mcpid_pkg::OP_PI, 13, 0, 0, 65535));
    send_sample(make_sample(mcpid_pkg::OP_PI, 8, 0, 0, -65536));
  endtask

  // Push the channel 12 integral into its limit from both sides.
  task automatic test_integral_clamp();
    repeat (3) send_sample(make_sample(mcpid_pkg::OP_PI, 12, 0, 0, 65535));
    repeat (2) send_sample(make_sample(mcpid_pkg::OP_PI, 12, 0, 0, -65536));
  endtask

  // Channels with zero integral and output limits must hold a zero drive.
  task automatic test_zero_limits();
    send_sample(make_sample(mcpid_pkg::OP_PID, 1, 1000, -1000, 0));
    send_sample(make_sample(mcpid_pkg::OP_PI, 16, 0, 0, 65535));
    send_sample(make_sample(mcpid_pkg::OP_PID, 10, -32768, 32767, 0));
  endtask

  // Samples for channels past the bank echo the channel with a zero drive.
  task automatic test_unused_channels();
    send_sample(make_sample(mcpid_pkg::OP_PID, N_LOOPS, 32767, -32768, 0));
    send_sample(make_sample(mcpid_pkg::OP_PI, 31, 0, 0, -65536));
    send_sample(make_sample(mcpid_pkg::OP_PID, 25, 100, -100, 0));
  endtask

  // Hold the drive side off while samples keep coming, so the pipeline fills and
  // the block has to stall its input.
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF;
    repeat (40) send_sample(random_sample());
  endtask

  task automatic run_random_phase(input int n, input int unsigned idle,
                                  input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_sample(random_sample());
  endtask

  initial begin
    int unsigned drain;
    for (int c = 0; c < N_LOOPS; c++) begin
      loop_integral[c] = 0;
      loop_prev_err[c] = 0;
    end
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_off_left       = 0;
    samples_sent        = 0;
    drives_checked      = 0;
    backpressure_cycles = 0;
    mismatches          = 0;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.operation     <= mcpid_pkg::OP_PID;
    in_if.channel       <= '0;
    in_if.setpoint      <= '0;
    in_if.measurement   <= '0;
    in_if.error_in      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_deadband();
    test_error_extremes();
    test_integral_clamp();
    test_zero_limits();
    test_unused_channels();
    directed_sent = samples_sent;

    test_output_hold();
    run_random_phase(440, 0, 0);
    run_random_phase(440, 82, 0);
    run_random_phase(440, 0, 82);
    run_random_phase(430, 16, 16);
    in_if.valid <= 1'b0;

    // Drain: let every outstanding drive come out, then a few pipeline lengths more.
    recv_stall_pct = 0;
    drain = 0;
    while (pending_drives.size() != 0 && drain < DRAIN_MAX) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_drives.size() != 0)
      report_mismatch("drives never delivered", 0, pending_drives.size());

    $display("Run covered %0d samples (%0d directed) over 20 loops and unused channels,",
             samples_sent, directed_sent);
    $display("%0d drives checked, %0d input stall cycles, %0d mismatches",
             drives_checked, backpressure_cycles, mismatches);
    if (mismatches == 0)
      $display("tb_multi_channel_pid_regulator OK");
    else
      $display("tb_multi_channel_pid_regulator NOT OK");
    $finish;
  end

endmodule
